// File: sv/i2c_master_transaction_engine_defines.svh
// assertion macros shared by the i2c master rtl
`ifndef I2C_MASTER_TRANSACTION_ENGINE_DEFINES_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define I2CM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cm same-cycle check failed");

// next-cycle implication, checked outside reset
`define I2CM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cm next-cycle check failed");

`endif

// File: sv/i2cm_pkg.sv
// types and constants of the i2c master transaction engine
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam int MODE_W     = 3;
    localparam int ADDR_W     = 7;
    localparam int DATA_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int BIT_CNT_W  = 4;
    localparam int BYTE_IDX_W = 2;
    localparam int HALF_PHASE_W_DEFAULT = 16;

    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;
    localparam logic [BYTE_W-1:0]    LAST_PROBE    = 8'hFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE    = 3'd0,
        MODE_WR_BYTE = 3'd1,
        MODE_WR_WORD = 3'd2,
        MODE_RD_BYTE = 3'd3,
        MODE_SEARCH  = 3'd4
    } mode_t;

    typedef enum logic [16:0] {
        ST_IDLE       = 17'b00000000000000001,
        ST_START      = 17'b00000000000000010,
        ST_START_LOW  = 17'b00000000000000100,
        ST_BIT_SETUP  = 17'b00000000000001000,
        ST_BIT_HIGH   = 17'b00000000000010000,
        ST_BIT_LOW    = 17'b00000000000100000,
        ST_ACK_SETUP  = 17'b00000000001000000,
        ST_ACK_HIGH   = 17'b00000000010000000,
        ST_ACK_LOW    = 17'b00000000100000000,
        ST_RD_HIGH    = 17'b00000001000000000,
        ST_RD_LOW     = 17'b00000010000000000,
        ST_MACK_SETUP = 17'b00000100000000000,
        ST_MACK_HIGH  = 17'b00001000000000000,
        ST_MACK_LOW   = 17'b00010000000000000,
        ST_STOP_SDA   = 17'b00100000000000000,
        ST_STOP_SCL   = 17'b01000000000000000,
        ST_STOP_END   = 17'b10000000000000000
    } state_t;

endpackage

// File: sv/i2c_master_transaction_engine.sv
// i2c master transaction engine: bus sequencer, result register and checks
`timescale 1ns / 1ps
`include "i2c_master_transaction_engine_defines.svh"

// Open-drain i2c master, advanced one clock of the bus engine per input beat.
// Input channel (in_valid/in_ready): mode, address, data and the sampled
// sda_in level. A command (write byte, write word, read byte, search) is
// taken only when the engine is idle; otherwise the command fields are
// ignored and the beat simply ticks the engine.
// Output channel (out_valid/out_ready): exactly one result beat per input
// beat, carrying the pin release levels, busy, done and the done-cycle
// status (ack_ok, read_data, found_valid, found_address).
// The result beat is registered and appears in the cycle after the input beat is accepted;
// throughput is one beat per cycle while the receiver is ready, set by the single result
// register, which is refilled in the same cycle it is drained.
// Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the extra hold
// count of each pin phase; it is always ready and is meant for idle times.
// Reset releases both pins, returns the engine to idle, clears the hold
// count and empties the result register.
// When the receiver stalls, in_ready falls and the engine state holds, so
// bus timing advances only with accepted beats.
module i2c_master_transaction_engine
    import i2cm_pkg::*;
#(
    parameter int HALF_PHASE_W = HALF_PHASE_W_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [HALF_PHASE_W-1:0] cfg_data,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [MODE_W-1:0]       mode,
    input  logic [ADDR_W-1:0]       address,
    input  logic [DATA_W-1:0]       data,
    input  logic                    sda_in,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    scl_release,
    output logic                    sda_release,
    output logic                    busy_res,
    output logic                    done_res,
    output logic                    ack_ok,
    output logic [BYTE_W-1:0]       read_data,
    output logic                    found_valid,
    output logic [BYTE_W-1:0]       found_address
);

    logic [HALF_PHASE_W-1:0] half_phase_reg;

    state_t                  step_reg, step_next;
    logic [HALF_PHASE_W-1:0] wait_reg, wait_next;
    logic [BIT_CNT_W-1:0]    bit_reg, bit_next;
    logic [BYTE_IDX_W-1:0]   byte_reg, byte_next;
    logic [BYTE_W-1:0]       shift_reg, shift_next;
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic [DATA_W-1:0]       word_reg, word_next;
    logic [BYTE_W-1:0]       probe_reg, probe_next;
    logic                    scl_reg, scl_next;
    logic                    sda_reg, sda_next;
    logic                    ack_reg, ack_next;
    logic                    done_next;
    logic                    accept;

    logic                    out_valid_reg;
    logic                    scl_out_reg, sda_out_reg, busy_out_reg, done_out_reg;
    logic                    ack_out_reg, found_out_reg;
    logic [BYTE_W-1:0]       read_out_reg, found_addr_out_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        step_next  = step_reg;
        wait_next  = wait_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        mode_next  = mode_reg;
        word_next  = word_reg;
        probe_next = probe_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        done_next  = 1'b0;

        if (step_reg == ST_IDLE)
        begin
            if (mode inside {[MODE_WR_BYTE:MODE_SEARCH]})
            begin
                mode_next  = mode;
                word_next  = data;
                byte_next  = '0;
                bit_next   = '0;
                ack_next   = 1'b0;
                probe_next = '0;
                if (mode == MODE_SEARCH)
                    shift_next = '0;
                else if (mode == MODE_RD_BYTE)
                    shift_next = {address, 1'b1};
                else
                    shift_next = {address, 1'b0};
                step_next = ST_START;
                wait_next = half_phase_reg;
                sda_next  = 1'b0;
            end
        end
        else if (wait_reg != '0)
        begin
            wait_next = wait_reg - 1'b1;
        end
        else
        begin
            // every phase change but the return to idle reloads the hold count
            wait_next = half_phase_reg;
            case (step_reg)
                ST_START:
                begin
                    step_next = ST_START_LOW;
                    scl_next  = 1'b0;
                end
                ST_START_LOW:
                begin
                    bit_next  = '0;
                    step_next = ST_BIT_SETUP;
                    sda_next  = shift_reg[BYTE_W-1];
                end
                ST_BIT_SETUP:
                begin
                    step_next = ST_BIT_HIGH;
                    scl_next  = 1'b1;
                end
                ST_BIT_HIGH:
                begin
                    step_next = ST_BIT_LOW;
                    scl_next  = 1'b0;
                end
                ST_BIT_LOW:
                begin
                    shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                    bit_next   = bit_reg + 1'b1;
                    if (bit_next >= BITS_PER_BYTE)
                    begin
                        step_next = ST_ACK_SETUP;
                        sda_next  = 1'b1;
                    end
                    else
                    begin
                        step_next = ST_BIT_SETUP;
                        sda_next  = shift_next[BYTE_W-1];
                    end
                end
                ST_ACK_SETUP:
                begin
                    step_next = ST_ACK_HIGH;
                    scl_next  = 1'b1;
                end
                ST_ACK_HIGH:
                begin
                    ack_next  = !sda_in;
                    step_next = ST_ACK_LOW;
                    scl_next  = 1'b0;
                end
                ST_ACK_LOW:
                begin
                    byte_next = byte_reg + 1'b1;
                    if (ack_reg && mode_reg == MODE_RD_BYTE && byte_next == 2'd1)
                    begin
                        shift_next = '0;
                        bit_next   = '0;
                        step_next  = ST_RD_HIGH;
                        scl_next   = 1'b1;
                    end
                    else if (ack_reg && ((mode_reg == MODE_WR_BYTE && byte_next == 2'd1)
                             || (mode_reg == MODE_WR_WORD && byte_next == 2'd2)))
                    begin
                        shift_next = word_reg[BYTE_W-1:0];
                        bit_next   = '0;
                        step_next  = ST_BIT_SETUP;
                        sda_next   = word_reg[BYTE_W-1];
                    end
                    else if (ack_reg && mode_reg == MODE_WR_WORD && byte_next == 2'd1)
                    begin
                        shift_next = word_reg[DATA_W-1:BYTE_W];
                        bit_next   = '0;
                        step_next  = ST_BIT_SETUP;
                        sda_next   = word_reg[DATA_W-1];
                    end
                    else
                    begin
                        if (mode_reg == MODE_RD_BYTE)
                            shift_next = '0;
                        step_next = ST_STOP_SDA;
                        sda_next  = 1'b0;
                    end
                end
                ST_RD_HIGH:
                begin
                    shift_next = {shift_reg[BYTE_W-2:0], sda_in};
                    bit_next   = bit_reg + 1'b1;
                    step_next  = ST_RD_LOW;
                    scl_next   = 1'b0;
                end
                ST_RD_LOW:
                begin
                    if (bit_reg >= BITS_PER_BYTE)
                    begin
                        step_next = ST_MACK_SETUP;
                        sda_next  = 1'b0;
                    end
                    else
                    begin
                        step_next = ST_RD_HIGH;
                        scl_next  = 1'b1;
                    end
                end
                ST_MACK_SETUP:
                begin
                    step_next = ST_MACK_HIGH;
                    scl_next  = 1'b1;
                end
                ST_MACK_HIGH:
                begin
                    step_next = ST_MACK_LOW;
                    scl_next  = 1'b0;
                end
                ST_MACK_LOW:
                begin
                    step_next = ST_STOP_SDA;
                    sda_next  = 1'b0;
                end
                ST_STOP_SDA:
                begin
                    step_next = ST_STOP_SCL;
                    scl_next  = 1'b1;
                end
                ST_STOP_SCL:
                begin
                    step_next = ST_STOP_END;
                    sda_next  = 1'b1;
                end
                ST_STOP_END:
                begin
                    // search moves on to the next probe until one acks or the last probe is reached
                    if (mode_reg == MODE_SEARCH && !ack_reg && probe_reg < LAST_PROBE)
                    begin
                        probe_next = probe_reg + 1'b1;
                        shift_next = probe_next;
                        byte_next  = '0;
                        step_next  = ST_START;
                        sda_next   = 1'b0;
                    end
                    else
                    begin
                        step_next = ST_IDLE;
                        wait_next = '0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    step_next = ST_IDLE;
                    wait_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_phase_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_phase_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_IDLE;
            wait_reg  <= '0;
            bit_reg   <= '0;
            byte_reg  <= '0;
            shift_reg <= '0;
            mode_reg  <= MODE_IDLE;
            word_reg  <= '0;
            probe_reg <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
        end
        else if (accept)
        begin
            step_reg  <= step_next;
            wait_reg  <= wait_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            mode_reg  <= mode_next;
            word_reg  <= word_next;
            probe_reg <= probe_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            scl_out_reg        <= scl_next;
            sda_out_reg        <= sda_next;
            busy_out_reg       <= step_next != ST_IDLE;
            done_out_reg       <= done_next;
            ack_out_reg        <= done_next && ack_next;
            read_out_reg       <= (done_next && ack_next && mode_next == MODE_RD_BYTE)
                                  ? shift_next : '0;
            found_out_reg      <= done_next && ack_next && mode_next == MODE_SEARCH;
            found_addr_out_reg <= (done_next && ack_next && mode_next == MODE_SEARCH)
                                  ? probe_next : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign scl_release   = scl_out_reg;
    assign sda_release   = sda_out_reg;
    assign busy_res      = busy_out_reg;
    assign done_res      = done_out_reg;
    assign ack_ok        = ack_out_reg;
    assign read_data     = read_out_reg;
    assign found_valid   = found_out_reg;
    assign found_address = found_addr_out_reg;

    `I2CM_ASSERT_NOW(a_done_bus_free, out_valid && done_res,
        !busy_res && scl_release && sda_release)
    `I2CM_ASSERT_NOW(a_idle_no_wait, step_reg == ST_IDLE, wait_reg == '0)
    `I2CM_ASSERT_NEXT(a_start_pulls_sda,
        accept && step_reg == ST_IDLE && mode == MODE_WR_BYTE,
        step_reg == ST_START && !sda_reg && scl_reg)
    `I2CM_ASSERT_NOW(a_found_with_done, out_valid && found_valid, done_res && ack_ok)
    `I2CM_ASSERT_NOW(a_read_with_done, out_valid && read_data != '0, done_res && ack_ok)

endmodule

// File: tb/tb_i2c_master_transaction_engine.sv
// self-checking testbench for the i2c master transaction engine
`timescale 1ns / 1ps

module tb_i2c_master_transaction_engine;
    import i2cm_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
    localparam logic [15:0]       HOLD_LONG        = 16'd20;
    localparam int unsigned       MAX_PRINTED      = 100;

    typedef enum logic [4:0] {
        P_IDLE       = 5'd0,
        P_START      = 5'd1,
        P_START_LOW  = 5'd2,
        P_BIT_SETUP  = 5'd3,
        P_BIT_HIGH   = 5'd4,
        P_BIT_LOW    = 5'd5,
        P_ACK_SETUP  = 5'd6,
        P_ACK_HIGH   = 5'd7,
        P_ACK_LOW    = 5'd8,
        P_RD_HIGH    = 5'd9,
        P_RD_LOW     = 5'd10,
        P_MACK_SETUP = 5'd11,
        P_MACK_HIGH  = 5'd12,
        P_MACK_LOW   = 5'd13,
        P_STOP_SDA   = 5'd14,
        P_STOP_SCL   = 5'd15,
        P_STOP_END   = 5'd16
    } bus_phase_t;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              busy;
        logic              done;
        logic              ack;
        logic [BYTE_W-1:0] rd_byte;
        logic              found;
        logic [BYTE_W-1:0] found_byte;
    } bus_cycle_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [15:0]         cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [MODE_W-1:0]   mode = MODE_IDLE;
    logic [ADDR_W-1:0]   address = '0;
    logic [DATA_W-1:0]   data = '0;
    logic                sda_in = 1'b1;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                scl_release;
    logic                sda_release;
    logic                busy_res;
    logic                done_res;
    logic                ack_ok;
    logic [BYTE_W-1:0]   read_data;
    logic                found_valid;
    logic [BYTE_W-1:0]   found_address;

    // predictor copy of the engine
    bus_phase_t          phase = P_IDLE;
    logic [15:0]         hold_left = '0;
    logic [3:0]          bit_cnt = '0;
    logic [1:0]          byte_cnt = '0;
    logic [7:0]          shifter = '0;
    logic [MODE_W-1:0]   cmd_mode = MODE_IDLE;
    logic [15:0]         cmd_word = '0;
    logic [8:0]          probe_addr = '0;
    logic                scl_lvl = 1'b1;
    logic                sda_lvl = 1'b1;
    logic                got_ack = 1'b0;
    logic [15:0]         hold_cfg = '0;

    bus_cycle_t          predicted_bus_cycles[$];

    // stimulus controls
    int unsigned         send_idle_pct = 0;
    int unsigned         recv_idle_pct = 0;
    int unsigned         stall_req = 0;
    int unsigned         stall_left = 0;
    int unsigned         beats_sent = 0;
    int unsigned         result_count = 0;
    int unsigned         error_count = 0;
    int unsigned         probe_ack_pct = 50;
    int unsigned         mid_cfg_permille = 0;
    logic [3:0]          ack_plan = 4'hF;
    int                  probe_target = -1;
    int                  rd_pattern = -1;
    int                  busy_fill = -1;

    i2c_master_transaction_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .mode          (mode),
        .address       (address),
        .data          (data),
        .sda_in        (sda_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .scl_release   (scl_release),
        .sda_release   (sda_release),
        .busy_res      (busy_res),
        .done_res      (done_res),
        .ack_ok        (ack_ok),
        .read_data     (read_data),
        .found_valid   (found_valid),
        .found_address (found_address)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void go_phase(bus_phase_t p);
        phase = p;
        hold_left = hold_cfg;
    endfunction

    function automatic void first_bit();
        bit_cnt = '0;
        go_phase(P_BIT_SETUP);
        sda_lvl = shifter[7];
    endfunction

    function automatic void stop_sequence();
        go_phase(P_STOP_SDA);
        sda_lvl = 1'b0;
    endfunction

    // closes the phase that has run out; returns 1 when the final stop of the command completes
    function automatic logic end_phase(logic s);
        case (phase)
            P_START:
            begin
                go_phase(P_START_LOW);
                scl_lvl = 1'b0;
            end
            P_START_LOW: first_bit();
            P_BIT_SETUP:
            begin
                go_phase(P_BIT_HIGH);
                scl_lvl = 1'b1;
            end
            P_BIT_HIGH:
            begin
                go_phase(P_BIT_LOW);
                scl_lvl = 1'b0;
            end
            P_BIT_LOW:
            begin
                shifter = shifter << 1;
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= BITS_PER_BYTE)
                begin
                    go_phase(P_ACK_SETUP);
                    sda_lvl = 1'b1;
                end
                else
                begin
                    go_phase(P_BIT_SETUP);
                    sda_lvl = shifter[7];
                end
            end
            P_ACK_SETUP:
            begin
                go_phase(P_ACK_HIGH);
                scl_lvl = 1'b1;
            end
            P_ACK_HIGH:
            begin
                got_ack = !s;
                go_phase(P_ACK_LOW);
                scl_lvl = 1'b0;
            end
            P_ACK_LOW:
            begin
                byte_cnt = byte_cnt + 2'd1;
                if (got_ack && cmd_mode == MODE_RD_BYTE && byte_cnt == 2'd1)
                begin
                    shifter = '0;
                    bit_cnt = '0;
                    go_phase(P_RD_HIGH);
                    scl_lvl = 1'b1;
                end
                else if (got_ack && cmd_mode == MODE_WR_BYTE && byte_cnt == 2'd1)
                begin
                    shifter = cmd_word[7:0];
                    first_bit();
                end
                else if (got_ack && cmd_mode == MODE_WR_WORD && byte_cnt == 2'd1)
                begin
                    shifter = cmd_word[15:8];
                    first_bit();
                end
                else if (got_ack && cmd_mode == MODE_WR_WORD && byte_cnt == 2'd2)
                begin
                    shifter = cmd_word[7:0];
                    first_bit();
                end
                else
                begin
                    if (cmd_mode == MODE_RD_BYTE)
                        shifter = '0;
                    stop_sequence();
                end
            end
            P_RD_HIGH:
            begin
                shifter = {shifter[6:0], s};
                bit_cnt = bit_cnt + 4'd1;
                go_phase(P_RD_LOW);
                scl_lvl = 1'b0;
            end
            P_RD_LOW:
            begin
                if (bit_cnt >= BITS_PER_BYTE)
                begin
                    go_phase(P_MACK_SETUP);
                    sda_lvl = 1'b0;
                end
                else
                begin
                    go_phase(P_RD_HIGH);
                    scl_lvl = 1'b1;
                end
            end
            P_MACK_SETUP:
            begin
                go_phase(P_MACK_HIGH);
                scl_lvl = 1'b1;
            end
            P_MACK_HIGH:
            begin
                go_phase(P_MACK_LOW);
                scl_lvl = 1'b0;
            end
            P_MACK_LOW: stop_sequence();
            P_STOP_SDA:
            begin
                go_phase(P_STOP_SCL);
                scl_lvl = 1'b1;
            end
            P_STOP_SCL:
            begin
                go_phase(P_STOP_END);
                sda_lvl = 1'b1;
            end
            P_STOP_END:
            begin
                // search moves on to the next address byte until one acks or the last probe is reached
                if (cmd_mode == MODE_SEARCH && !got_ack && probe_addr < {1'b0, LAST_PROBE})
                begin
                    probe_addr = probe_addr + 9'd1;
                    shifter = probe_addr[7:0];
                    byte_cnt = '0;
                    go_phase(P_START);
                    sda_lvl = 1'b0;
                end
                else
                begin
                    phase = P_IDLE;
                    hold_left = '0;
                    return 1'b1;
                end
            end
            default:
            begin
                phase = P_IDLE;
                hold_left = '0;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic bus_cycle_t step_bus_engine(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
                                                   logic [DATA_W-1:0] d, logic s);
        bus_cycle_t r;
        logic       fin;
        fin = 1'b0;
        r = '0;
        if (phase == P_IDLE)
        begin
            if (m >= MODE_WR_BYTE && m <= MODE_SEARCH)
            begin
                cmd_mode = m;
                cmd_word = d;
                byte_cnt = '0;
                bit_cnt = '0;
                got_ack = 1'b0;
                probe_addr = '0;
                if (m == MODE_SEARCH)
                    shifter = '0;
                else if (m == MODE_RD_BYTE)
                    shifter = {a, 1'b1};
                else
                    shifter = {a, 1'b0};
                go_phase(P_START);
                sda_lvl = 1'b0;
            end
        end
        else if (hold_left != 0)
            hold_left = hold_left - 16'd1;
        else
            fin = end_phase(s);

        r.scl = scl_lvl;
        r.sda = sda_lvl;
        r.busy = (phase != P_IDLE);
        r.done = fin;
        if (fin)
        begin
            r.ack = got_ack;
            if (cmd_mode == MODE_RD_BYTE && got_ack)
                r.rd_byte = shifter;
            if (cmd_mode == MODE_SEARCH && got_ack)
            begin
                r.found = 1'b1;
                r.found_byte = probe_addr[7:0];
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("beat %0d %s: got %0h, expected %0h",
                                      result_count, name, got, want));
    endtask

    always @(posedge clk)
    begin
        bus_cycle_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_bus_cycles.size() == 0)
                report_mismatch($sformatf("beat %0d arrived with nothing expected", result_count));
            else
            begin
                want = predicted_bus_cycles.pop_front();
                check_field("scl_release", 8'(scl_release), 8'(want.scl));
                check_field("sda_release", 8'(sda_release), 8'(want.sda));
                check_field("busy_res", 8'(busy_res), 8'(want.busy));
                check_field("done_res", 8'(done_res), 8'(want.done));
                check_field("ack_ok", 8'(ack_ok), 8'(want.ack));
                check_field("read_data", read_data, want.rd_byte);
                check_field("found_valid", 8'(found_valid), 8'(want.found));
                check_field("found_address", found_address, want.found_byte);
            end
            result_count++;
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (stall_req != 0)
        begin
            stall_left = stall_req;
            stall_req = 0;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        #(64'd50_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------- driving

    task automatic send_beat(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a,
                             logic [DATA_W-1:0] d, logic s);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        address <= a;
        data <= d;
        sda_in <= s;
        do
            @(posedge clk);
        while (!in_ready);
        predicted_bus_cycles.push_back(step_bus_engine(m, a, d, s));
        beats_sent++;
    endtask

    task automatic stop_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_input();
        while (predicted_bus_cycles.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_half_phase(logic [15:0] v);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        hold_cfg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // slave side of the bus as seen on sda_in for the beat about to go out
    function automatic logic pick_sda();
        logic ack_it;
        if (hold_left == 0 && phase == P_ACK_HIGH)
        begin
            if (cmd_mode == MODE_SEARCH)
                ack_it = (probe_target >= 0) ? (int'(probe_addr) == probe_target)
                                             : ($urandom_range(0, 99) < probe_ack_pct);
            else
                ack_it = ack_plan[byte_cnt];
            return !ack_it;
        end
        if (hold_left == 0 && phase == P_RD_HIGH && rd_pattern >= 0)
            return rd_pattern[7 - bit_cnt];
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [15:0] pick_hold();
        return 16'($urandom_range(0, 1));
    endfunction

    task automatic send_tick();
        logic [MODE_W-1:0] m;
        m = (busy_fill < 0) ? MODE_W'($urandom_range(0, 7)) : MODE_W'(busy_fill);
        send_beat(m, ADDR_W'($urandom_range(0, 127)), DATA_W'($urandom_range(0, 65535)),
                  pick_sda());
    endtask

    task automatic finish_command();
        while (phase != P_IDLE)
        begin
            if (mid_cfg_permille != 0 && $urandom_range(0, 999) < mid_cfg_permille)
                write_half_phase(pick_hold());
            send_tick();
        end
    endtask

    task automatic run_command(logic [MODE_W-1:0] m, logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
        send_beat(m, a, d, pick_sda());
        finish_command();
    endtask

    task automatic send_noise();
        logic [MODE_W-1:0] m;
        m = $urandom_range(0, 1) ? MODE_IDLE
                                 : MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
        send_beat(m, ADDR_W'($urandom_range(0, 127)), DATA_W'($urandom_range(0, 65535)),
                  1'($urandom_range(0, 1)));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_write_byte();
        ack_plan = 4'hF;
        run_command(MODE_WR_BYTE, 7'h7F, 16'h5A96);
    endtask

    task automatic test_write_word();
        ack_plan = 4'hF;
        run_command(MODE_WR_WORD, 7'h55, 16'hA5C3);
    endtask

    task automatic test_read_byte();
        ack_plan = 4'hF;
        rd_pattern = 8'hA5;
        run_command(MODE_RD_BYTE, 7'h2A, 16'h1234);
        rd_pattern = -1;
    endtask

    // nack on the address byte, on the data byte of a byte write and on the second byte of a word write ends in a stop
    task automatic test_nack_abort();
        ack_plan = 4'b0000;
        run_command(MODE_WR_BYTE, 7'h11, 16'h00C3);
        ack_plan = 4'b0001;
        run_command(MODE_WR_BYTE, 7'h22, 16'h003C);
        ack_plan = 4'b0011;
        run_command(MODE_WR_WORD, 7'h44, 16'hCAFE);
        ack_plan = 4'b0000;
        run_command(MODE_RD_BYTE, 7'h66, 16'h0000);
        ack_plan = 4'hF;
    endtask

    // unused modes while idle, and full commands offered while busy
    task automatic test_ignored_commands();
        send_beat(MODE_IDLE, 7'h7F, 16'hFFFF, 1'b0);
        send_beat(MODE_SPARE_FIRST, 7'h00, 16'h0000, 1'b1);
        send_beat(MODE_SPARE_MID, 7'h7F, 16'hFFFF, 1'b0);
        send_beat(MODE_SPARE_LAST, 7'h55, 16'hAAAA, 1'b1);
        ack_plan = 4'hF;
        busy_fill = MODE_SEARCH;
        run_command(MODE_WR_BYTE, 7'h3C, 16'h0081);
        busy_fill = -1;
    endtask

    task automatic test_search();
        probe_target = 0;
        run_command(MODE_SEARCH, 7'h7F, 16'hFFFF);
        probe_target = 1;
        run_command(MODE_SEARCH, 7'h00, 16'h0000);
        probe_target = -1;
    endtask

    task automatic test_phase_hold();
        ack_plan = 4'hF;
        rd_pattern = 8'hFF;
        write_half_phase(16'd1);
        run_command(MODE_RD_BYTE, 7'h25, 16'h0000);
        rd_pattern = -1;
        write_half_phase(16'd0);
    endtask

    // receiver holds off long enough for the result register to fill
    task automatic test_backpressure();
        ack_plan = 4'hF;
        wait_drained();
        stall_req = 300;
        run_command(MODE_WR_BYTE, 7'h12, 16'h3456);
        repeat (8) send_noise();
    endtask

    task automatic test_random_traffic(int unsigned min_beats, int unsigned min_cmds);
        int unsigned       start_beats;
        int unsigned       cmds;
        logic [MODE_W-1:0] m;
        start_beats = beats_sent;
        cmds = 0;
        probe_target = -1;
        rd_pattern = -1;
        busy_fill = -1;
        probe_ack_pct = 50;
        mid_cfg_permille = 3;
        while (beats_sent - start_beats < min_beats || cmds < min_cmds)
        begin
            if ($urandom_range(0, 7) == 0)
                write_half_phase(pick_hold());
            repeat ($urandom_range(0, 3)) send_noise();
            for (int i = 0; i < 4; i++)
                ack_plan[i] = ($urandom_range(0, 99) < 85);
            m = MODE_W'($urandom_range(MODE_WR_BYTE, MODE_SEARCH));
            run_command(m, ADDR_W'($urandom_range(0, 127)), DATA_W'($urandom_range(0, 65535)));
            cmds++;
        end
        mid_cfg_permille = 0;
    endtask

    // long hold, changed while the first phase is still counting down
    task automatic test_long_phase();
        ack_plan = 4'b0000;
        write_half_phase(HOLD_LONG);
        send_beat(MODE_WR_BYTE, 7'h69, 16'h00C3, pick_sda());
        while (phase == P_START && hold_left > 16'd15)
            send_tick();
        write_half_phase(16'd2);
        finish_command();
        write_half_phase(16'd0);
        ack_plan = 4'hF;
    endtask

    initial
    begin
        send_idle_pct = 38;
        recv_idle_pct = 58;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_half_phase(16'd0);
        test_write_byte();
        test_write_word();
        test_read_byte();
        test_nack_abort();
        test_ignored_commands();
        test_search();
        test_phase_hold();
        test_backpressure();

        send_idle_pct = 58;
        recv_idle_pct = 38;
        test_random_traffic(100, 1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(100, 1);
        test_long_phase();

        wait_drained();
        repeat (4) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: i2c_master_transaction_engine.f
+incdir+sv
sv/i2cm_pkg.sv
sv/i2c_master_transaction_engine.sv
tb/tb_i2c_master_transaction_engine.sv
